[rtl/crcdf_pkg.sv]
`timescale 1ns / 1ps
package crcdf_pkg;

  localparam logic [7:0]  HDR_SYNC0   = 8'h55;
  localparam logic [7:0]  HDR_SYNC1   = 8'h66;
  localparam logic [7:0]  CTL_RSVD    = 8'hFC;
  localparam logic [1:0]  CTL_ACK     = 2'd2;
  localparam logic [15:0] CRC_POLY    = 16'h1021;

  localparam logic [1:0]  KIND_PAYLOAD = 2'd0;
  localparam logic [1:0]  KIND_FRAME   = 2'd1;
  localparam logic [1:0]  KIND_DGRAM   = 2'd2;

  localparam logic [2:0]  ERR_NONE    = 3'd0;
  localparam logic [2:0]  ERR_HEADER  = 3'd1;
  localparam logic [2:0]  ERR_CONTROL = 3'd2;
  localparam logic [2:0]  ERR_CRC     = 3'd3;
  localparam logic [2:0]  ERR_TRUNC   = 3'd4;

  localparam int          POS_W        = 17;
  localparam logic [16:0] POS_SYNC0    = 17'd0;
  localparam logic [16:0] POS_SYNC1    = 17'd1;
  localparam logic [16:0] POS_CTL      = 17'd2;
  localparam logic [16:0] POS_LEN_LO   = 17'd3;
  localparam logic [16:0] POS_LEN_HI   = 17'd4;
  localparam logic [16:0] POS_SEQ_LO   = 17'd5;
  localparam logic [16:0] POS_SEQ_HI   = 17'd6;
  localparam logic [16:0] POS_CMD      = 17'd7;
  localparam logic [16:0] POS_PAYLOAD  = 17'd8;

  localparam int          QUEUE_DEPTH_DEF = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_in_datagram;
  } rx_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [1:0]  control_bits;
    logic        is_ack;
    logic [15:0] sequence_number;
    logic [7:0]  command_code;
    logic [15:0] payload_length;
    logic        good;
    logic [2:0]  error_code;
    logic        last_result;
  } result_t;

  // one queue entry: optional payload/frame result, optional datagram result
  typedef struct packed {
    logic    has_prim;
    result_t prim;
    logic    has_dgram;
    logic    dgram_good;
    logic [2:0] dgram_err;
  } q_entry_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

[rtl/crcdf_front.sv]
`timescale 1ns / 1ps
module crcdf_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                rx_valid,
  output logic                rx_ready,
  input  crcdf_pkg::rx_t      rx,
  output logic                push,
  output crcdf_pkg::q_entry_t entry,
  input  logic                q_full
);

  logic [16:0] pos, pos_next;
  logic [15:0] len_h, len_h_next;
  logic [1:0]  ctl_h, ctl_h_next;
  logic [15:0] seq_h, seq_h_next;
  logic [7:0]  cmd_h, cmd_h_next;
  logic [15:0] crc, crc_next;
  logic [7:0]  crc_lo, crc_lo_next;
  logic [2:0]  derr, derr_next;
  logic        seen, seen_next;

  logic [16:0] crc_at;
  logic        acc;
  logic        crc_ok;
  logic [7:0]  b;

  assign rx_ready = !q_full;
  assign acc      = rx_valid && rx_ready;
  assign b        = rx.data_byte;
  assign crc_at   = crcdf_pkg::POS_PAYLOAD + {1'b0, len_h};
  assign crc_ok   = ({b, crc_lo} == crc);

  always_comb begin
    pos_next    = pos;
    len_h_next  = len_h;
    ctl_h_next  = ctl_h;
    seq_h_next  = seq_h;
    cmd_h_next  = cmd_h;
    crc_next    = crc;
    crc_lo_next = crc_lo;
    derr_next   = derr;
    seen_next   = seen;
    entry       = '0;
    if (derr == crcdf_pkg::ERR_NONE) begin
      pos_next = pos + 17'd1;
      if (pos < crc_at) begin
        crc_next = crcdf_pkg::crc_byte(crc, b);
      end
      priority if (pos == crcdf_pkg::POS_SYNC0) begin
        if (b != crcdf_pkg::HDR_SYNC0) derr_next = crcdf_pkg::ERR_HEADER;
      end else if (pos == crcdf_pkg::POS_SYNC1) begin
        if (b != crcdf_pkg::HDR_SYNC1) derr_next = crcdf_pkg::ERR_HEADER;
      end else if (pos == crcdf_pkg::POS_CTL) begin
        if ((b & crcdf_pkg::CTL_RSVD) != 8'h00) derr_next = crcdf_pkg::ERR_CONTROL;
        ctl_h_next = b[1:0];
      end else if (pos == crcdf_pkg::POS_LEN_LO) begin
        len_h_next = {8'h00, b};
      end else if (pos == crcdf_pkg::POS_LEN_HI) begin
        len_h_next = {b, len_h[7:0]};
      end else if (pos == crcdf_pkg::POS_SEQ_LO) begin
        seq_h_next = {8'h00, b};
      end else if (pos == crcdf_pkg::POS_SEQ_HI) begin
        seq_h_next = {b, seq_h[7:0]};
      end else if (pos == crcdf_pkg::POS_CMD) begin
        cmd_h_next = b;
      end else if (pos < crc_at) begin
        entry.has_prim           = 1'b1;
        entry.prim.kind          = crcdf_pkg::KIND_PAYLOAD;
        entry.prim.payload_byte  = b;
        entry.prim.payload_index = 16'(pos - crcdf_pkg::POS_PAYLOAD);
      end else if (pos == crc_at) begin
        crc_lo_next = b;
      end else begin
        entry.has_prim             = 1'b1;
        entry.prim.kind            = crcdf_pkg::KIND_FRAME;
        entry.prim.control_bits    = ctl_h;
        entry.prim.is_ack          = crc_ok && (ctl_h == crcdf_pkg::CTL_ACK);
        entry.prim.sequence_number = seq_h;
        entry.prim.command_code    = cmd_h;
        entry.prim.payload_length  = len_h;
        entry.prim.good            = crc_ok;
        entry.prim.error_code      = crc_ok ? crcdf_pkg::ERR_NONE : crcdf_pkg::ERR_CRC;
        seen_next = 1'b1;
        if (!crc_ok) derr_next = crcdf_pkg::ERR_CRC;
        pos_next   = '0;
        crc_next   = '0;
        len_h_next = '0;
      end
    end
    entry.prim.last_result = !rx.last_in_datagram;
    if (rx.last_in_datagram) begin
      entry.has_dgram = 1'b1;
      if (derr_next == crcdf_pkg::ERR_NONE && pos_next != '0) begin
        entry.dgram_err = crcdf_pkg::ERR_TRUNC;
      end else begin
        entry.dgram_err = derr_next;
      end
      entry.dgram_good = (entry.dgram_err == crcdf_pkg::ERR_NONE) && seen_next;
    end
  end

  assign push = acc && (entry.has_prim || entry.has_dgram);

  always_ff @(posedge clk) begin
    if (rst || (acc && rx.last_in_datagram)) begin
      pos    <= '0;
      len_h  <= '0;
      ctl_h  <= '0;
      seq_h  <= '0;
      cmd_h  <= '0;
      crc    <= '0;
      crc_lo <= '0;
      derr   <= crcdf_pkg::ERR_NONE;
      seen   <= 1'b0;
    end else if (acc) begin
      pos    <= pos_next;
      len_h  <= len_h_next;
      ctl_h  <= ctl_h_next;
      seq_h  <= seq_h_next;
      cmd_h  <= cmd_h_next;
      crc    <= crc_next;
      crc_lo <= crc_lo_next;
      derr   <= derr_next;
      seen   <= seen_next;
    end
  end

endmodule

[rtl/crcdf_queue.sv]
`timescale 1ns / 1ps
module crcdf_queue #(
  parameter int DEPTH = crcdf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  crcdf_pkg::q_entry_t wr_entry,
  input  logic                pop,
  output crcdf_pkg::q_entry_t head,
  output logic                empty,
  output logic                full
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  crcdf_pkg::q_entry_t mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CW'(DEPTH));
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + AW'(1);
      if (pop)  rd_ptr <= rd_ptr + AW'(1);
      unique case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("queue count out of range");

endmodule

[rtl/crcdf_back.sv]
`timescale 1ns / 1ps
module crcdf_back (
  input  logic                clk,
  input  logic                rst,
  input  crcdf_pkg::q_entry_t head,
  input  logic                empty,
  output logic                pop,
  output logic                result_valid,
  input  logic                result_ready,
  output crcdf_pkg::result_t  result
);

  logic               second, second_next;
  logic               load;
  crcdf_pkg::result_t nxt;
  logic               emit_prim;

  assign load      = !result_valid || result_ready;
  assign emit_prim = head.has_prim && !second;

  always_comb begin
    nxt         = '0;
    pop         = 1'b0;
    second_next = second;
    if (emit_prim) begin
      nxt             = head.prim;
      nxt.last_result = !head.has_dgram;
    end else begin
      nxt.kind        = crcdf_pkg::KIND_DGRAM;
      nxt.good        = head.dgram_good;
      nxt.error_code  = head.dgram_err;
      nxt.last_result = 1'b1;
    end
    if (load && !empty) begin
      if (emit_prim && head.has_dgram) begin
        second_next = 1'b1;
      end else begin
        pop         = 1'b1;
        second_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      second       <= 1'b0;
    end else begin
      second <= second_next;
      if (load) result_valid <= !empty;
    end
  end

  always_ff @(posedge clk) begin
    if (load && !empty) result <= nxt;
  end

  a_second_needs_dgram: assert property (@(posedge clk) disable iff (rst)
    (second && !empty) |-> head.has_dgram)
    else $error("second phase on entry without datagram result");
  a_second_after_prim: assert property (@(posedge clk) disable iff (rst)
    $rose(second) |-> (result_valid && result.last_result == 1'b0))
    else $error("datagram phase entered without a pending frame-level result");
  a_dgram_is_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.kind == crcdf_pkg::KIND_DGRAM) |-> result.last_result)
    else $error("datagram result not flagged last");

endmodule

[rtl/crc16_framed_datagram_deframer.sv]
`timescale 1ns / 1ps
// Byte-stream deframer for datagrams of back-to-back CRC-16/XMODEM frames.
// Input channel rx (rx_valid/rx_ready): one datagram byte per transaction,
// last_in_datagram set on the final byte.
// Output channel result (result_valid/result_ready): payload bytes as they
// arrive (kind 0), a frame summary at each frame end (kind 1) and a datagram
// summary on the flagged byte (kind 2). Payload bytes of a frame whose summary
// reports good = 0 must be dropped by the consumer.
// Throughput: one byte per cycle while the queue is not full; the last byte of
// a datagram may give two results, which are presented one after the other.
// Each result is written into the queue at the edge that accepts its byte and
// is loaded into the output register once that register is free.
// Reset clears the parser, empties the queue and drops result_valid; the
// parser also returns to its reset state after each flagged last byte.
// When result_ready is low the output holds and the queue fills; rx_ready
// drops once the queue is full and rises as soon as space frees up.
module crc16_framed_datagram_deframer #(
  parameter int QUEUE_DEPTH = crcdf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               rx_valid,
  output logic               rx_ready,
  input  crcdf_pkg::rx_t     rx,
  output logic               result_valid,
  input  logic               result_ready,
  output crcdf_pkg::result_t result
);

  logic                push;
  logic                pop;
  logic                q_empty;
  logic                q_full;
  crcdf_pkg::q_entry_t wr_entry;
  crcdf_pkg::q_entry_t head;

  crcdf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_ready (rx_ready),
    .rx       (rx),
    .push     (push),
    .entry    (wr_entry),
    .q_full   (q_full)
  );

  crcdf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  crcdf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (q_empty),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

[tb/crc16_framed_datagram_deframer_test.sv]
`timescale 1ns / 1ps
module crc16_framed_datagram_deframer_test;
  import crcdf_pkg::*;

  localparam int PARSED_TARGET  = 1850;
  localparam int STALL_LIMIT    = 2000;
  localparam int DIRECTED_COUNT = 27;

  typedef enum logic [1:0] {
    SRC_LITERAL,
    SRC_CRC_LO,
    SRC_CRC_HI,
    SRC_CRC_BAD_HI
  } byte_src_e;

  typedef struct packed {
    byte_src_e  src;
    logic [7:0] value;
    logic       last;
    logic       typed;
    logic       good;
    logic [2:0] err;
  } directed_row_t;

  // typed rows carry the datagram verdict that ends them
  localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{SRC_LITERAL,    8'h00, 1'b1, 1'b1, 1'b0, ERR_HEADER},
    '{SRC_LITERAL,    8'h55, 1'b1, 1'b1, 1'b0, ERR_TRUNC},
    '{SRC_LITERAL,    8'h55, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{SRC_LITERAL,    8'h66, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{SRC_LITERAL,    8'hFC, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{SRC_LITERAL,    8'hFF, 1'b1, 1'b1, 1'b0, ERR_CONTROL},
    '{SRC_LITERAL,    8'h55, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{SRC_LITERAL,    8'h66, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{SRC_LITERAL,    8'h02, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{SRC_LITERAL,    8'h01, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{SRC_LITERAL,    8'h00, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{SRC_LITERAL,    8'hFF, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{SRC_LITERAL,    8'hFF, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{SRC_LITERAL,    8'hFF, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{SRC_LITERAL,    8'h80, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{SRC_CRC_LO,     8'h00, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{SRC_CRC_HI,     8'h00, 1'b1, 1'b1, 1'b1, ERR_NONE},
    '{SRC_LITERAL,    8'h55, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{SRC_LITERAL,    8'h66, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{SRC_LITERAL,    8'h01, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{SRC_LITERAL,    8'h00, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{SRC_LITERAL,    8'h00, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{SRC_LITERAL,    8'h00, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{SRC_LITERAL,    8'h00, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{SRC_LITERAL,    8'h00, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{SRC_CRC_LO,     8'h00, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{SRC_CRC_BAD_HI, 8'h00, 1'b1, 1'b1, 1'b0, ERR_CRC}
  };

  logic    clk;
  logic    rst;
  logic    rx_valid;
  logic    rx_ready;
  rx_t     rx;
  logic    result_valid;
  logic    result_ready;
  result_t result;

  // deframer state as predicted
  logic [16:0] frame_pos;
  logic [15:0] len_held;
  logic [15:0] seq_held;
  logic [15:0] crc_acc;
  logic [1:0]  ctl_held;
  logic [7:0]  cmd_held;
  logic [7:0]  crc_lo_rx;
  logic [2:0]  dgram_err;
  logic        frame_done;

  result_t    awaited_results[$];
  logic [7:0] datagram_bytes[$];
  int         bytes_parsed;
  int         mismatches;
  int         quiet_cycles;
  bit         sender_burst;

  crc16_framed_datagram_deframer DUT (
    .clk          (clk),
    .rst          (rst),
    .rx_valid     (rx_valid),
    .rx_ready     (rx_ready),
    .rx           (rx),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #10 clk = ~clk;

  function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int k = 7; k >= 0; k--) begin
      fb = c[15] ^ b[k];
      c  = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ 16'h1021;
      end
    end
    return c;
  endfunction

  task automatic clear_deframe_state();
    frame_pos  = '0;
    len_held   = '0;
    seq_held   = '0;
    crc_acc    = '0;
    ctl_held   = '0;
    cmd_held   = '0;
    crc_lo_rx  = '0;
    dgram_err  = ERR_NONE;
    frame_done = 1'b0;
  endtask

  task automatic deframe_byte(input rx_t item);
    result_t     outs[2];
    int          n;
    logic [16:0] crc_at;
    logic [7:0]  b;
    logic [2:0]  verdict;
    logic        ok;
    n = 0;
    b = item.data_byte;
    bytes_parsed++;
    if (dgram_err == ERR_NONE) begin
      crc_at = POS_PAYLOAD + {1'b0, len_held};
      if (frame_pos < crc_at) begin
        crc_acc = crc16_step(crc_acc, b);
      end
      if (frame_pos == POS_SYNC0) begin
        if (b != HDR_SYNC0) dgram_err = ERR_HEADER;
      end else if (frame_pos == POS_SYNC1) begin
        if (b != HDR_SYNC1) dgram_err = ERR_HEADER;
      end else if (frame_pos == POS_CTL) begin
        if ((b & CTL_RSVD) != 8'h00) dgram_err = ERR_CONTROL;
        ctl_held = b[1:0];
      end else if (frame_pos == POS_LEN_LO) begin
        len_held = {8'h00, b};
      end else if (frame_pos == POS_LEN_HI) begin
        len_held = {b, len_held[7:0]};
      end else if (frame_pos == POS_SEQ_LO) begin
        seq_held = {8'h00, b};
      end else if (frame_pos == POS_SEQ_HI) begin
        seq_held = {b, seq_held[7:0]};
      end else if (frame_pos == POS_CMD) begin
        cmd_held = b;
      end else if (frame_pos < crc_at) begin
        outs[n] = '0;
        outs[n].kind = KIND_PAYLOAD;
        outs[n].payload_byte = b;
        outs[n].payload_index = 16'(frame_pos - POS_PAYLOAD);
        n++;
      end else if (frame_pos == crc_at) begin
        crc_lo_rx = b;
      end else begin
        ok = ({b, crc_lo_rx} == crc_acc);
        outs[n] = '0;
        outs[n].kind = KIND_FRAME;
        outs[n].control_bits = ctl_held;
        outs[n].is_ack = ok && (ctl_held == CTL_ACK);
        outs[n].sequence_number = seq_held;
        outs[n].command_code = cmd_held;
        outs[n].payload_length = len_held;
        outs[n].good = ok;
        outs[n].error_code = ok ? ERR_NONE : ERR_CRC;
        n++;
        frame_done = 1'b1;
        if (!ok) dgram_err = ERR_CRC;
        crc_acc  = '0;
        len_held = '0;
      end
      if (n > 0 && outs[n-1].kind == KIND_FRAME) begin
        frame_pos = '0;
      end else begin
        frame_pos = frame_pos + 17'd1;
      end
    end
    if (item.last_in_datagram) begin
      verdict = dgram_err;
      if (verdict == ERR_NONE && frame_pos != '0) verdict = ERR_TRUNC;
      outs[n] = '0;
      outs[n].kind = KIND_DGRAM;
      outs[n].good = (verdict == ERR_NONE) && frame_done;
      outs[n].error_code = verdict;
      n++;
      clear_deframe_state();
    end
    for (int i = 0; i < n; i++) begin
      outs[i].last_result = (i == n - 1);
      awaited_results.push_back(outs[i]);
    end
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  task automatic send_byte(input rx_t item, input bit typed, input result_t typed_res);
    int n;
    rx       <= item;
    rx_valid <= 1'b1;
    do @(posedge clk); while (!rx_ready);
    deframe_byte(item);
    if (typed) begin
      void'(awaited_results.pop_back());
      awaited_results.push_back(typed_res);
    end
    n = sender_burst ? 0 : gap_len();
    if (n > 0) begin
      rx_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    rx_valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  task automatic append_noise(input int count);
    repeat (count) datagram_bytes.push_back(8'($urandom));
  endtask

  task automatic append_frame(input logic [1:0] ctl, input int len, input logic [15:0] seq,
                              input logic [7:0] cmd, input bit corrupt);
    logic [15:0] crc;
    int          start;
    start = datagram_bytes.size();
    datagram_bytes.push_back(HDR_SYNC0);
    datagram_bytes.push_back(HDR_SYNC1);
    datagram_bytes.push_back({6'd0, ctl});
    datagram_bytes.push_back(8'(len));
    datagram_bytes.push_back(8'(len >> 8));
    datagram_bytes.push_back(seq[7:0]);
    datagram_bytes.push_back(seq[15:8]);
    datagram_bytes.push_back(cmd);
    append_noise(len);
    crc = '0;
    for (int i = start; i < datagram_bytes.size(); i++) begin
      crc = crc16_step(crc, datagram_bytes[i]);
    end
    if (corrupt) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    datagram_bytes.push_back(crc[7:0]);
    datagram_bytes.push_back(crc[15:8]);
  endtask

  task automatic build_datagram();
    int         mode;
    int         r;
    int         len;
    logic [7:0] b;
    datagram_bytes.delete();
    mode = $urandom_range(0, 99);
    if (mode < 70) begin
      repeat ($urandom_range(1, 3)) begin
        len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 6) : $urandom_range(7, 24);
        append_frame(2'($urandom_range(0, 3)), len, 16'($urandom), 8'($urandom),
                     $urandom_range(0, 99) < 8);
      end
      r = $urandom_range(0, 99);
      if (r < 10) begin
        repeat ($urandom_range(1, datagram_bytes.size() - 1)) void'(datagram_bytes.pop_back());
      end else if (r < 15) begin
        append_noise($urandom_range(1, 4));
      end
    end else if (mode < 80) begin
      if ($urandom_range(0, 1) == 1) begin
        datagram_bytes.push_back(HDR_SYNC0);
        do b = 8'($urandom); while (b == HDR_SYNC1);
      end else begin
        do b = 8'($urandom); while (b == HDR_SYNC0);
      end
      datagram_bytes.push_back(b);
      append_noise($urandom_range(0, 5));
    end else if (mode < 88) begin
      datagram_bytes.push_back(HDR_SYNC0);
      datagram_bytes.push_back(HDR_SYNC1);
      datagram_bytes.push_back(8'($urandom_range(4, 255)));
      append_noise($urandom_range(0, 5));
    end else if (mode < 94) begin
      // declared length far beyond what follows
      datagram_bytes.push_back(HDR_SYNC0);
      datagram_bytes.push_back(HDR_SYNC1);
      datagram_bytes.push_back(8'($urandom_range(0, 3)));
      append_noise($urandom_range(4, 10));
    end else begin
      append_noise($urandom_range(1, 8));
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    bit      moved;
    moved = 1'b0;
    if (!rst) begin
      if (result_valid && result_ready) begin
        moved = 1'b1;
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, got %h", $time, result);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          check_field("kind", want.kind, result.kind);
          check_field("payload_byte", want.payload_byte, result.payload_byte);
          check_field("payload_index", want.payload_index, result.payload_index);
          check_field("control_bits", want.control_bits, result.control_bits);
          check_field("is_ack", want.is_ack, result.is_ack);
          check_field("sequence_number", want.sequence_number, result.sequence_number);
          check_field("command_code", want.command_code, result.command_code);
          check_field("payload_length", want.payload_length, result.payload_length);
          check_field("good", want.good, result.good);
          check_field("error_code", want.error_code, result.error_code);
          check_field("last_result", want.last_result, result.last_result);
        end
      end
      if (rx_valid && rx_ready) moved = 1'b1;
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("crc16_framed_datagram_deframer_test: errors");
        $finish;
      end
    end
  end

  initial begin
    int hold;
    int stall;
    result_ready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      hold = ($urandom_range(0, 99) < 70) ? $urandom_range(1, 4) : $urandom_range(20, 80);
      result_ready <= 1'b1;
      repeat (hold) @(posedge clk);
      stall = $urandom_range(0, 99);
      stall = (stall < 50) ? 0 : (stall < 85) ? $urandom_range(1, 3) : $urandom_range(4, 30);
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    directed_row_t row;
    rx_t           item;
    result_t       typed_res;
    clk          = 1'b0;
    rst          = 1'b1;
    rx_valid     = 1'b0;
    rx           = '0;
    bytes_parsed = 0;
    mismatches   = 0;
    quiet_cycles = 0;
    sender_burst = 1'b0;
    clear_deframe_state();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      row = DIRECTED_ROWS[i];
      case (row.src)
        SRC_CRC_LO:     item.data_byte = crc_acc[7:0];
        SRC_CRC_HI:     item.data_byte = crc_acc[15:8];
        SRC_CRC_BAD_HI: item.data_byte = ~crc_acc[15:8];
        default:        item.data_byte = row.value;
      endcase
      item.last_in_datagram = row.last;
      typed_res = '0;
      typed_res.kind = KIND_DGRAM;
      typed_res.good = row.good;
      typed_res.error_code = row.err;
      typed_res.last_result = 1'b1;
      send_byte(item, row.typed, typed_res);
    end
    drain_results();

    bytes_parsed = 0;
    while (bytes_parsed < PARSED_TARGET) begin
      build_datagram();
      sender_burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < datagram_bytes.size(); i++) begin
        item.data_byte = datagram_bytes[i];
        item.last_in_datagram = (i == datagram_bytes.size() - 1);
        send_byte(item, 1'b0, '0);
      end
      if ($urandom_range(0, 19) == 0) drain_results();
    end
    drain_results();
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("crc16_framed_datagram_deframer_test: clean");
    end else begin
      $display("crc16_framed_datagram_deframer_test: errors");
    end
    $finish;
  end

endmodule

[files.f]
rtl/crcdf_pkg.sv
rtl/crcdf_front.sv
rtl/crcdf_queue.sv
rtl/crcdf_back.sv
rtl/crc16_framed_datagram_deframer.sv
tb/crc16_framed_datagram_deframer_test.sv
